@@ design/lpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpa_pkg: shared types and constants of the LED pulse animator
// Transaction payloads, configuration set, animation state and mode codes.
// ----------------------------------------------------------------------------
package lpa_pkg;

	localparam int LevelMax = 255;

	localparam logic [1:0] MODE_IDLE        = 2'd0;
	localparam logic [1:0] MODE_PULSING     = 2'd1;
	localparam logic [1:0] MODE_TURNING_OFF = 2'd2;

	localparam logic [1:0] REG_PULSE_TARGET      = 2'd0;
	localparam logic [1:0] REG_FADE_STEP         = 2'd1;
	localparam logic [1:0] REG_PULSE_INTERVAL_MS = 2'd2;

	localparam logic signed [8:0] STEP_MIN_RAW     = -9'sd256;
	localparam logic signed [8:0] STEP_MIN_CLAMPED = -9'sd255;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now_ms;
	} lpa_in_t;

	typedef struct packed {
		logic [7:0] pwm_level;
		logic [1:0] anim_mode;
	} lpa_out_t;

	typedef struct packed {
		logic [7:0]        pulse_target;
		logic signed [8:0] fade_step;
		logic [15:0]       pulse_interval_ms;
	} lpa_cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [10:0] brightness;
		logic signed [8:0]  current_step;
		logic [7:0]         pulses_done;
		logic [31:0]        last_step_time;
	} lpa_state_t;

endpackage
`default_nettype wire

@@ design/lpa_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpa_core: next-state and result logic of the LED pulse animator
// Applies one call (start request and service) to the current state.
// ----------------------------------------------------------------------------
module lpa_core (
	input  var lpa_pkg::lpa_state_t cur_state,
	input  var lpa_pkg::lpa_in_t    item,
	input  var lpa_pkg::lpa_cfg_t   cfg,
	output var lpa_pkg::lpa_state_t nxt_state,
	output var lpa_pkg::lpa_out_t   result
);

	lpa_pkg::lpa_state_t st;
	logic [31:0]         elapsed;
	logic signed [11:0]  sum;
	logic signed [11:0]  level_max;

	assign level_max = 12'(lpa_pkg::LevelMax);

	// start request, taken only in idle
	always_comb begin
		st = cur_state;
		if (item.req_type && cur_state.mode == lpa_pkg::MODE_IDLE) begin
			st.pulses_done    = 8'd0;
			st.last_step_time = item.now_ms;
			st.brightness     = 11'sd0;
			st.current_step   = (cfg.fade_step == lpa_pkg::STEP_MIN_RAW) ?
				lpa_pkg::STEP_MIN_CLAMPED : cfg.fade_step;
			st.mode           = lpa_pkg::MODE_PULSING;
		end
	end

	assign elapsed = item.now_ms - st.last_step_time;
	assign sum     = {st.brightness[10], st.brightness} +
		{{3{st.current_step[8]}}, st.current_step};

	// service
	always_comb begin
		nxt_state = st;
		unique case (st.mode)
			lpa_pkg::MODE_PULSING: begin
				if (st.pulses_done < cfg.pulse_target) begin
					if (elapsed >= {16'd0, cfg.pulse_interval_ms}) begin
						nxt_state.last_step_time = item.now_ms;
						nxt_state.brightness     = sum[10:0];
						if (sum <= 12'sd0 || sum >= level_max) begin
							nxt_state.current_step = -st.current_step;
							if (sum <= 12'sd0) begin
								nxt_state.pulses_done = st.pulses_done + 8'd1;
							end
						end
					end
				end else begin
					nxt_state.mode = lpa_pkg::MODE_TURNING_OFF;
				end
			end
			lpa_pkg::MODE_TURNING_OFF: begin
				nxt_state.brightness = 11'sd0;
				nxt_state.mode       = lpa_pkg::MODE_IDLE;
			end
			default: begin
				nxt_state.mode = lpa_pkg::MODE_IDLE;
				if (st.brightness < 11'(lpa_pkg::LevelMax)) begin
					nxt_state.brightness = st.brightness + 11'sd1;
				end
			end
		endcase
	end

	// saturate to the duty range
	always_comb begin
		result.anim_mode = nxt_state.mode;
		if (nxt_state.brightness < 11'sd0) begin
			result.pwm_level = 8'd0;
		end else if (nxt_state.brightness > 11'(lpa_pkg::LevelMax)) begin
			result.pwm_level = 8'(lpa_pkg::LevelMax);
		end else begin
			result.pwm_level = nxt_state.brightness[7:0];
		end
	end

endmodule
`default_nettype wire

@@ design/led_pulse_animator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// led_pulse_animator: breathing-fade LED pulse animator
// Idle, pulsing and turning-off modes driven by calls carrying millisecond time.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   in_data   (req_type, now_ms)
//  out      out_valid / out_ready out_data  (pwm_level, anim_mode)
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
//  One transaction per clock while results are taken. Each accepted transaction is
//  held in an input register and resolved combinationally by the next-state logic,
//  which writes the animation state and result register and raises out_valid.
//  A stalled result holds the input register; in_ready drops only when both are full.
//  Reset clears the handshake and animation state and restores the configuration
//  defaults.
// ----------------------------------------------------------------------------
module led_pulse_animator (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic              in_valid,
	output var logic              in_ready,
	input  var lpa_pkg::lpa_in_t  in_data,
	output var logic              out_valid,
	input  var logic              out_ready,
	output var lpa_pkg::lpa_out_t out_data,
	input  var logic              cfg_valid,
	output var logic              cfg_ready,
	input  var logic [1:0]        cfg_index,
	input  var logic [15:0]       cfg_data
);

	lpa_pkg::lpa_cfg_t   cfg_q;
	lpa_pkg::lpa_state_t state_q;
	lpa_pkg::lpa_state_t state_nxt;
	lpa_pkg::lpa_in_t    item_s1;
	lpa_pkg::lpa_out_t   result;
	lpa_pkg::lpa_out_t   out_q;
	logic                valid_s1;
	logic                out_valid_q;
	logic                advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_target      <= 8'd1;
			cfg_q.fade_step         <= 9'sd5;
			cfg_q.pulse_interval_ms <= 16'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lpa_pkg::REG_PULSE_TARGET:      cfg_q.pulse_target <= cfg_data[7:0];
				lpa_pkg::REG_FADE_STEP:         cfg_q.fade_step <= cfg_data[8:0];
				lpa_pkg::REG_PULSE_INTERVAL_MS: cfg_q.pulse_interval_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	lpa_core u_core (
		.cur_state (state_q),
		.item      (item_s1),
		.cfg       (cfg_q),
		.nxt_state (state_nxt),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= lpa_pkg::MODE_IDLE;
			state_q.brightness     <= 11'sd0;
			state_q.current_step   <= 9'sd0;
			state_q.pulses_done    <= 8'd0;
			state_q.last_step_time <= 32'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low without a stalled result");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(state_q))
		else $error("animation state moved during an output stall");

	a_turn_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.mode == lpa_pkg::MODE_TURNING_OFF) |=>
		(state_q.brightness == 11'sd0 && state_q.mode == lpa_pkg::MODE_IDLE))
		else $error("turning off did not clear brightness");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.current_step != lpa_pkg::STEP_MIN_RAW)
		else $error("fade step reached the unreversible minimum");

endmodule
`default_nettype wire

@@ bench/lpa_checker.sv @@
// ----------------------------------------------------------------------------
// lpa_checker: result checker for the LED pulse animator
// Watches the configuration, call and result channels. Keeps its own copy of
// the settings and animation state, works out the level and mode of every
// accepted call, and compares each accepted result against the oldest one due.
// ----------------------------------------------------------------------------
module lpa_checker (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic              in_valid,
	input  var logic              in_ready,
	input  var lpa_pkg::lpa_in_t  in_data,
	input  var logic              out_valid,
	input  var logic              out_ready,
	input  var lpa_pkg::lpa_out_t out_data,
	input  var logic              cfg_valid,
	input  var logic              cfg_ready,
	input  var logic [1:0]        cfg_index,
	input  var logic [15:0]       cfg_data,
	output var int unsigned       fail_count,
	output var int unsigned       pending
);

	logic [7:0]         target_cfg;
	logic signed [8:0]  step_cfg;
	logic [15:0]        interval_cfg;
	logic [1:0]         mode;
	logic signed [10:0] brightness;
	logic signed [8:0]  cur_step;
	logic [7:0]         pulses_done;
	logic [31:0]        last_step_ms;
	lpa_pkg::lpa_out_t  levels_due[$];
	int unsigned        reported;

	function automatic lpa_pkg::lpa_out_t animate_call(input lpa_pkg::lpa_in_t call_in);
		logic [31:0]       elapsed;
		lpa_pkg::lpa_out_t res;
		if (call_in.req_type && mode == lpa_pkg::MODE_IDLE) begin
			pulses_done  = '0;
			last_step_ms = call_in.now_ms;
			brightness   = '0;
			cur_step     = (step_cfg == lpa_pkg::STEP_MIN_RAW) ?
				lpa_pkg::STEP_MIN_CLAMPED : step_cfg;
			mode         = lpa_pkg::MODE_PULSING;
		end
		unique case (mode)
			lpa_pkg::MODE_PULSING: begin
				if (pulses_done < target_cfg) begin
					elapsed = call_in.now_ms - last_step_ms;
					if (elapsed >= {16'd0, interval_cfg}) begin
						last_step_ms = call_in.now_ms;
						brightness   = brightness + cur_step;
						if (brightness <= 0 || brightness >= lpa_pkg::LevelMax) begin
							cur_step = -cur_step;
							if (brightness <= 0)
								pulses_done = pulses_done + 8'd1;
						end
					end
				end else begin
					mode = lpa_pkg::MODE_TURNING_OFF;
				end
			end
			lpa_pkg::MODE_TURNING_OFF: begin
				brightness = '0;
				mode       = lpa_pkg::MODE_IDLE;
			end
			default: begin
				mode = lpa_pkg::MODE_IDLE;
				if (brightness < lpa_pkg::LevelMax)
					brightness = brightness + 11'sd1;
			end
		endcase
		if (brightness < 0)
			res.pwm_level = 8'd0;
		else if (brightness > lpa_pkg::LevelMax)
			res.pwm_level = 8'(lpa_pkg::LevelMax);
		else
			res.pwm_level = brightness[7:0];
		res.anim_mode = mode;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lpa_pkg::lpa_out_t want;
		if (!arst_n) begin
			target_cfg   = 8'd1;
			step_cfg     = 9'sd5;
			interval_cfg = 16'd10;
			mode         = lpa_pkg::MODE_IDLE;
			brightness   = '0;
			cur_step     = '0;
			pulses_done  = '0;
			last_step_ms = '0;
			levels_due.delete();
			fail_count   = 0;
			reported     = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lpa_pkg::REG_PULSE_TARGET:      target_cfg   = cfg_data[7:0];
					lpa_pkg::REG_FADE_STEP:         step_cfg     = cfg_data[8:0];
					lpa_pkg::REG_PULSE_INTERVAL_MS: interval_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				levels_due.push_back(animate_call(in_data));
			if (out_valid && out_ready) begin
				if (levels_due.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("%0t: unexpected result: pwm_level %0d anim_mode %0d",
							$time, out_data.pwm_level, out_data.anim_mode);
					end
				end else begin
					want = levels_due.pop_front();
					if (out_data.pwm_level != want.pwm_level ||
							out_data.anim_mode != want.anim_mode) begin
						fail_count++;
						if (reported < 10) begin
							reported++;
							$display("%0t: pwm_level exp %0d got %0d, anim_mode exp %0d got %0d",
								$time, want.pwm_level, out_data.pwm_level,
								want.anim_mode, out_data.anim_mode);
						end
					end
				end
			end
		end
		pending = levels_due.size();
	end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: top level for the LED pulse animator
// Directed calls over the setting extremes and special cases, then random
// phases of start and service calls with varied timing. Both channels idle
// and stall at random; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned ITEM_GOAL   = 1450;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	lpa_pkg::lpa_in_t  in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	lpa_pkg::lpa_out_t out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [15:0]       cfg_data  = '0;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned items_sent   = 0;
	int unsigned cycles       = 0;
	bit          calm         = 1'b0;
	bit          long_hold    = 1'b0;
	logic [31:0] clock_ms     = '0;
	logic [15:0] cur_interval = 16'd10;

	led_pulse_animator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lpa_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned stall_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned call_gap();
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return stall_len();
	endfunction

	function automatic logic [31:0] advance_clock();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			clock_ms = clock_ms + cur_interval + $urandom_range(0, 3);
		else if (r < 75)
			clock_ms = clock_ms + $urandom_range(0, cur_interval);
		else if (r < 85)
			clock_ms = clock_ms;
		else if (r < 95)
			clock_ms = clock_ms - $urandom_range(1, 5);
		else
			clock_ms = $urandom;
		return clock_ms;
	endfunction

	task automatic call(input logic req, input logic [31:0] now);
		int unsigned gap;
		gap = call_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{req_type: req, now_ms: now};
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// hold until every result is back and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [7:0] target, input logic [8:0] step,
			input logic [15:0] interval);
		write_reg(lpa_pkg::REG_PULSE_TARGET, {8'($urandom), target});
		write_reg(lpa_pkg::REG_FADE_STEP, {7'($urandom), step});
		write_reg(lpa_pkg::REG_PULSE_INTERVAL_MS, interval);
		cfg_valid    <= 1'b0;
		cur_interval = interval;
	endtask

	initial begin : result_sink
		int unsigned n;
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b0;
				n = stall_len();
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("led_pulse_animator verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned       phase;
		int unsigned       n;
		int unsigned       r;
		logic [7:0]        target;
		logic [8:0]        step;
		logic [15:0]       interval;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ramp and default start, busy start ignored
		call(1'b0, 32'h0000_0000);
		call(1'b0, 32'hFFFF_FFFF);
		call(1'b1, 32'd1000);
		call(1'b1, 32'd1005);
		call(1'b0, 32'd1010);
		settle();

		// zero interval, full step loaded while still pulsing: start ignored, old step runs on
		load_settings(8'd2, 9'd255, 16'd0);
		repeat (6) call(1'b0 | (items_sent == 5), 32'h8000_0000);
		settle();

		// target zero turns off at once
		load_settings(8'd0, 9'h100, 16'd65535);
		call(1'b1, 32'hFFFF_FFF0);
		call(1'b0, 32'h0000_0000);
		settle();

		// most negative step, widest interval, time wrap
		load_settings(8'd255, 9'h100, 16'd65535);
		call(1'b1, 32'hFFFF_FFF0);
		call(1'b0, 32'h0000_FFEE);
		call(1'b0, 32'h0000_FFEF);
		call(1'b0, 32'h0001_FFEF);
		settle();

		// zero step loaded while the last pulse still runs: start ignored, target reached
		load_settings(8'd3, 9'd0, 16'd0);
		call(1'b1, 32'd7);
		repeat (4) call(1'b0, 32'd7);

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			settle();
			r = $urandom_range(0, 99);
			if (r < 10)
				target = 8'd0;
			else if (r < 18)
				target = 8'd255;
			else
				target = 8'($urandom_range(1, 3));
			r = $urandom_range(0, 99);
			if (r < 10)
				step = 9'h100;
			else if (r < 15)
				step = 9'd0;
			else if (r < 22)
				step = 9'd255;
			else if (r < 28)
				step = 9'h101;
			else begin
				step = 9'($urandom_range(20, 255));
				if ($urandom_range(0, 1) == 1)
					step = -step;
			end
			r = $urandom_range(0, 99);
			if (r < 15)
				interval = 16'd0;
			else if (r < 22)
				interval = 16'hFFFF;
			else
				interval = 16'($urandom_range(1, 40));
			load_settings(target, step, interval);

			calm = (phase == 1) || (phase % 6 == 4);
			n    = $urandom_range(30, 90);
			if (phase == 1) begin
				long_hold = 1'b1;
				n         = 60;
			end
			if ($urandom_range(0, 4) == 0)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
			else
				clock_ms = $urandom;

			call(1'b1, clock_ms);
			for (int unsigned k = 1; k < n; k++)
				call($urandom_range(0, 99) < 8, advance_clock());
			phase++;
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("led_pulse_animator verification clean");
		else
			$display("led_pulse_animator verification failed");
		$finish;
	end

endmodule
